// ----- rtl/mfbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfbp_pkg: shared types and constants of the MSB-first bit packer
// Holds the operation codes, the size constants and the job record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package mfbp_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] FUNC_APPEND  = 2'd0;
    localparam logic [1:0] FUNC_FLUSH   = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam int unsigned MAX_BUFFER_BYTES = 4096;
    localparam int unsigned CODE_WIDTH       = 32;
    localparam int unsigned BITS_PER_BYTE    = 8;
    localparam int unsigned QUEUE_DEPTH      = 4;

    localparam int unsigned CAP_W   = 13;   // capacity register and write position
    localparam int unsigned OIDX_W  = 12;   // byte index on the output
    localparam int unsigned NBITS_W = 6;    // code length field
    localparam int unsigned ACC_W   = 40;   // pending bits plus longest code, rounded

    // Register addresses (byte address / 4)
    localparam logic REG_BUFFER_BYTES = 1'b0;

    // One accepted item after classification: up to four finished bytes
    typedef struct packed {
        logic [2:0]            nbytes;    // 0 means one result without a byte
        logic [3:0][7:0]       data;      // data[3] is the first byte
        logic [OIDX_W-1:0]     base;      // buffer index of the first byte
        logic                  accepted;
    } job_t;

endpackage
`default_nettype wire

// ----- rtl/mfbp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfbp_front: classify and pack incoming items
// Runs the fit test, merges the code into the pending byte with one barrel
// shift, updates the stream state and builds the job for the back end.
// ----------------------------------------------------------------------------
module mfbp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire logic [1:0]                    func,
    input  wire logic [31:0]                   code,
    input  wire logic [mfbp_pkg::NBITS_W-1:0]  code_bits,
    input  wire logic [mfbp_pkg::CAP_W-1:0]    cap,
    output mfbp_pkg::job_t                     job
);

    logic [7:0]                  partial_reg, partial_next;
    logic [3:0]                  free_reg, free_next;
    logic [mfbp_pkg::CAP_W-1:0]  wi_reg, wi_next;

    logic [mfbp_pkg::NBITS_W-1:0] nbits;
    logic [3:0]                   pend;
    logic [31:0]                  mask;
    logic [mfbp_pkg::ACC_W-1:0]   acc;
    logic [5:0]                   shamt;
    logic [5:0]                   total;
    logic [2:0]                   nbytes;
    logic [16:0]                  diff;
    logic [19:0]                  room;
    logic                         fits;

    always_comb
    begin
        nbits  = (code_bits > 6'(mfbp_pkg::CODE_WIDTH)) ? 6'(mfbp_pkg::CODE_WIDTH) : code_bits;
        pend   = 4'd8 - free_reg;
        mask   = (nbits >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
        shamt  = 6'd40 - {2'b00, pend} - nbits;
        acc    = {partial_reg, 32'd0} | ({8'd0, code & mask} << shamt);
        total  = {2'b00, pend} + nbits;
        nbytes = total[5:3];
        // Room left in bits, signed: capacity may sit below the write position
        diff   = {4'd0, cap} - {4'd0, wi_reg};
        room   = {diff, 3'b000};
        fits   = $signed({14'd0, total}) <= $signed(room);
    end

    always_comb
    begin
        partial_next = partial_reg;
        free_next    = free_reg;
        wi_next      = wi_reg;
        job          = '0;
        unique case (func)
            mfbp_pkg::FUNC_APPEND:
            begin
                if (fits)
                begin
                    job.accepted = 1'b1;
                    job.nbytes   = nbytes;
                    job.data     = acc[39:8];
                    job.base     = wi_reg[mfbp_pkg::OIDX_W-1:0];
                    wi_next      = wi_reg + {10'd0, nbytes};
                    free_next    = 4'd8 - {1'b0, total[2:0]};
                    unique case (nbytes)
                        3'd0:    partial_next = acc[39:32];
                        3'd1:    partial_next = acc[31:24];
                        3'd2:    partial_next = acc[23:16];
                        3'd3:    partial_next = acc[15:8];
                        default: partial_next = acc[7:0];
                    endcase
                end
            end
            mfbp_pkg::FUNC_FLUSH:
            begin
                if (free_reg == 4'd8)
                begin
                    job.accepted = 1'b1;
                end
                else if (wi_reg >= cap)
                begin
                    // Drop the pending bits, nothing fits
                    partial_next = 8'd0;
                    free_next    = 4'd8;
                end
                else
                begin
                    job.accepted = 1'b1;
                    job.nbytes   = 3'd1;
                    job.data     = {partial_reg, 24'd0};
                    job.base     = wi_reg[mfbp_pkg::OIDX_W-1:0];
                    wi_next      = wi_reg + 13'd1;
                    partial_next = 8'd0;
                    free_next    = 4'd8;
                end
            end
            mfbp_pkg::FUNC_RESTART:
            begin
                job.accepted = 1'b1;
                partial_next = 8'd0;
                free_next    = 4'd8;
                wi_next      = '0;
            end
            default:
            begin
                job.accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 8'd0;
            free_reg    <= 4'd8;
            wi_reg      <= '0;
        end
        else if (take)
        begin
            partial_reg <= partial_next;
            free_reg    <= free_next;
            wi_reg      <= wi_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mfbp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfbp_queue: job queue between front end and back end
// Small first-in first-out store of job records; full blocks the front end.
// ----------------------------------------------------------------------------
module mfbp_queue #(
    parameter int unsigned DEPTH = mfbp_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mfbp_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output mfbp_pkg::job_t      head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mfbp_pkg::job_t   store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mfbp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfbp_back: emit the results of queued jobs
// Walks the bytes of the head job one per cycle into the output register, while
// it is empty or out_ready is high, and releases the job with its last result.
// ----------------------------------------------------------------------------
module mfbp_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         job_valid,
    input  wire mfbp_pkg::job_t               job,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              out_byte_valid,
    output logic [7:0]                        out_value,
    output logic [mfbp_pkg::OIDX_W-1:0]       out_index,
    output logic                              out_accepted,
    output logic                              out_last
);

    logic [1:0]                  k_reg;
    logic                        valid_reg;
    logic                        bvalid_reg;
    logic [7:0]                  value_reg;
    logic [mfbp_pkg::OIDX_W-1:0] index_reg;
    logic                        acc_reg;
    logic                        last_reg;

    logic                        load;
    logic                        has_byte;
    logic                        is_last;
    logic [7:0]                  cur_byte;

    always_comb
    begin
        has_byte = (job.nbytes != 3'd0);
        is_last  = !has_byte || ({1'b0, k_reg} == job.nbytes - 3'd1);
        load     = job_valid && (!valid_reg || out_ready);
        pop      = load && is_last;
        unique case (k_reg)
            2'd0: cur_byte = job.data[3];
            2'd1: cur_byte = job.data[2];
            2'd2: cur_byte = job.data[1];
            2'd3: cur_byte = job.data[0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                k_reg     <= is_last ? 2'd0 : k_reg + 2'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bvalid_reg <= has_byte;
            value_reg  <= has_byte ? cur_byte : 8'd0;
            index_reg  <= has_byte ? job.base + {10'd0, k_reg} : '0;
            acc_reg    <= job.accepted;
            last_reg   <= is_last;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte_valid = bvalid_reg;
    assign out_value      = value_reg;
    assign out_index      = index_reg;
    assign out_accepted   = acc_reg;
    assign out_last       = last_reg;

endmodule
`default_nettype wire

// ----- rtl/msb_first_bit_packer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_packer: variable-length code packer, MSB first
// Appends codes into a byte buffer of limited capacity and streams out the
// finished bytes with their buffer positions.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one transaction per operation. tuser selects append,
//    flush or restart; tdata carries the code and its length.
//  - Output stream (m_*): one transaction per finished byte, or a single
//    status transaction when an operation finishes no byte. tlast marks the
//    final transaction caused by one input.
//  - APB port: register 0 at address 0 holds the buffer capacity in bytes.
//    Write it only while the packer is idle.
//  - Path: an accepted input is written to the job queue, then its first result
//    is loaded into the output register that drives m_tvalid.
//  - Throughput: one input per cycle while each input yields one result and
//    m_tready is high; the single output register drains the job queue one
//    byte per cycle while m_tready is high; an n-byte input holds it for n bytes.
//  - The front end keeps accepting until the job queue (QUEUE_DEPTH jobs) is
//    full, so a stalled receiver backs up into s_tready only after that.
//  - Reset empties the queue, drops any pending bits, returns the write
//    position to zero and sets the capacity to 4096 bytes.
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
    parameter int unsigned QUEUE_DEPTH = mfbp_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] code, [37:32] code_bits, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] func

    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] byte_value, [19:8] byte_index, rest zero
    output logic [1:0]       m_tuser,   // [0] byte_valid, [1] accepted
    output logic             m_tlast,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [mfbp_pkg::CAP_W-1:0] CAP_MAX = mfbp_pkg::CAP_W'(mfbp_pkg::MAX_BUFFER_BYTES);

    logic [mfbp_pkg::CAP_W-1:0]  buffer_bytes_reg;
    logic [mfbp_pkg::CAP_W-1:0]  cap;
    logic                        take;
    logic                        q_full;
    logic                        q_not_empty;
    logic                        q_pop;
    mfbp_pkg::job_t              front_job;
    mfbp_pkg::job_t              head_job;
    logic                        out_byte_valid;
    logic [7:0]                  out_value;
    logic [mfbp_pkg::OIDX_W-1:0] out_index;
    logic                        out_accepted;

    // ---- configuration: capacity register, clamped to the buffer size where it is used
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_bytes_reg <= mfbp_pkg::CAP_W'(4096);
        end
        else if (psel && penable && pwrite && (paddr[2] == mfbp_pkg::REG_BUFFER_BYTES))
        begin
            buffer_bytes_reg <= pwdata[mfbp_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == mfbp_pkg::REG_BUFFER_BYTES)
                  ? {19'd0, buffer_bytes_reg} : 32'd0;
    assign cap    = (buffer_bytes_reg > CAP_MAX) ? CAP_MAX : buffer_bytes_reg;

    // ---- front end: accept while the job queue has room
    assign s_tready = !q_full;
    assign take     = s_tvalid && !q_full;

    mfbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .func      (s_tuser),
        .code      (s_tdata[31:0]),
        .code_bits (s_tdata[37:32]),
        .cap       (cap),
        .job       (front_job)
    );

    mfbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    // ---- back end: one result per cycle into the output register while m_tready is high
    mfbp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (q_not_empty),
        .job            (head_job),
        .pop            (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte_valid (out_byte_valid),
        .out_value      (out_value),
        .out_index      (out_index),
        .out_accepted   (out_accepted),
        .out_last       (m_tlast)
    );

    assign m_tdata = {4'd0, out_index, out_value};
    assign m_tuser = {out_accepted, out_byte_valid};

endmodule
`default_nettype wire

// ----- tb/tb_msb_first_bit_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer: self-checking bench for the MSB-first bit packer
// Streams append, flush and restart operations into the packer under several
// buffer capacities and handshake pacings. An in-bench packing model predicts
// every output transaction. A monitor compares each one in order.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer;

    // Opcode the packer ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // One input operation as it travels on the slave side
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] code;
        logic [5:0]  nbits;
    } packer_item_t;

    // One output transaction as seen on the master side
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  byte_value;
        logic [11:0] byte_index;
        logic        accepted;
        logic        last;
    } packer_byte_t;

    logic        clk;
    logic        rst_n    = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;     // [31:0] code, [37:32] code_bits, rest zero
    logic [1:0]  s_tuser  = '0;     // [1:0] func

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] byte_value, [19:8] byte_index, rest zero
    logic [1:0]  m_tuser;           // [0] byte_valid, [1] accepted
    logic        m_tlast;

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    msb_first_bit_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Operations waiting to be driven, and bytes the packer still owes us
    packer_item_t ops_to_send [$];
    packer_byte_t expected_bytes [$];

    // Model copy of the packer state and its capacity register
    logic [12:0] cap_reg   = 13'd4096;
    logic [7:0]  pend_byte = 8'h00;
    int          free_bits = 8;
    logic [12:0] wr_pos    = '0;

    // Pacing knobs, percent of cycles spent idle or stalled
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        in_taken      = 1'b0;

    // Run statistics
    int          mismatches    = 0;
    int          bytes_checked = 0;
    int          appends = 0, rejects = 0, flushes = 0, restarts = 0, unused_ops = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up if the packer hangs
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic packer_byte_t make_result(logic v, logic [7:0] val,
                                                 logic [11:0] idx, logic acc);
        packer_byte_t r;
        r.byte_valid = v;
        r.byte_value = val;
        r.byte_index = idx;
        r.accepted   = acc;
        r.last       = 1'b0;
        return r;
    endfunction

    // Apply one accepted operation to the model state and queue the
    // transactions it must produce, tlast on the final one.
    task automatic advance_packer(input packer_item_t it);
        packer_byte_t outs [0:3];
        int n;
        int nbits;
        int room;
        int cap;
        int k;
        n   = 0;
        cap = (int'(cap_reg) > int'(mfbp_pkg::MAX_BUFFER_BYTES))
            ? int'(mfbp_pkg::MAX_BUFFER_BYTES) : int'(cap_reg);
        case (it.op)
            mfbp_pkg::FUNC_APPEND:
            begin
                appends++;
                // Clamp overlong codes to the code width
                nbits = (int'(it.nbits) > int'(mfbp_pkg::CODE_WIDTH))
                      ? int'(mfbp_pkg::CODE_WIDTH) : int'(it.nbits);
                // Room can go negative once the capacity drops below the write position
                room  = (cap - int'(wr_pos)) * 8 - (8 - free_bits);
                if (nbits > room)
                begin
                    rejects++;
                    outs[n] = make_result(1'b0, 8'h00, 12'h000, 1'b0);
                    n++;
                end
                else
                begin
                    // Fill the highest free bit first, code MSB first
                    for (k = nbits; k > 0; k--)
                    begin
                        pend_byte[free_bits - 1] = it.code[k - 1];
                        free_bits--;
                        if (free_bits == 0)
                        begin
                            outs[n] = make_result(1'b1, pend_byte, wr_pos[11:0], 1'b1);
                            n++;
                            wr_pos++;
                            pend_byte = 8'h00;
                            free_bits = 8;
                        end
                    end
                    if (n == 0)
                    begin
                        outs[n] = make_result(1'b0, 8'h00, 12'h000, 1'b1);
                        n++;
                    end
                end
            end
            mfbp_pkg::FUNC_FLUSH:
            begin
                flushes++;
                if (free_bits == 8)
                begin
                    outs[n] = make_result(1'b0, 8'h00, 12'h000, 1'b1);
                end
                else if (int'(wr_pos) >= cap)
                begin
                    // Beyond capacity: drop the pending bits
                    pend_byte = 8'h00;
                    free_bits = 8;
                    outs[n]   = make_result(1'b0, 8'h00, 12'h000, 1'b0);
                end
                else
                begin
                    outs[n]   = make_result(1'b1, pend_byte, wr_pos[11:0], 1'b1);
                    wr_pos++;
                    pend_byte = 8'h00;
                    free_bits = 8;
                end
                n++;
            end
            mfbp_pkg::FUNC_RESTART:
            begin
                restarts++;
                pend_byte = 8'h00;
                free_bits = 8;
                wr_pos    = '0;
                outs[n]   = make_result(1'b0, 8'h00, 12'h000, 1'b1);
                n++;
            end
            default:
            begin
                unused_ops++;
                outs[n] = make_result(1'b0, 8'h00, 12'h000, 1'b0);
                n++;
            end
        endcase
        outs[n - 1].last = 1'b1;
        for (k = 0; k < n; k++)
            expected_bytes.push_back(outs[k]);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Input driver: hold tvalid until the transaction is taken, then advance
    always @(negedge clk)
    begin : drive_input
        packer_item_t it;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (ops_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, it.nbits, it.code};
                s_tuser  <= it.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Input monitor: predict on every accepted transaction
    always @(posedge clk)
    begin : watch_input
        packer_item_t it;
        in_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            it.op    = s_tuser;
            it.code  = s_tdata[31:0];
            it.nbits = s_tdata[37:32];
            advance_packer(it);
        end
    end

    // Output monitor: compare against the oldest expected transaction
    always @(posedge clk)
    begin : watch_output
        packer_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output transaction: tdata 0x%0h tuser 0x%0h tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                check_field("byte_valid", want.byte_valid, m_tuser[0]);
                check_field("byte_value", want.byte_value, m_tdata[7:0]);
                check_field("byte_index", want.byte_index, m_tdata[19:8]);
                check_field("accepted",   want.accepted,   m_tuser[1]);
                check_field("last",       want.last,       m_tlast);
                check_field("pad",        0,               m_tdata[23:20]);
            end
        end
    end

    task automatic push_op(input logic [1:0] op, input logic [31:0] code,
                           input logic [5:0] nbits);
        packer_item_t it;
        it.op    = op;
        it.code  = code;
        it.nbits = nbits;
        ops_to_send.push_back(it);
    endtask

    // Block until every queued operation went out and every byte came back
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (ops_to_send.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    endtask

    // Idle the packer, then write the capacity register over APB
    task automatic write_capacity(input logic [12:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mfbp_pkg::REG_BUFFER_BYTES, 2'b00};
        pwdata  <= {19'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg  = value;
    endtask

    // Mostly appends with random content and length, plus flushes, restarts
    // and the odd unused opcode. Pause the sender once until fully drained.
    task automatic run_random_phase(input logic [12:0] cap, input int idle,
                                    input int stall, input int count);
        int k;
        int pick;
        int pause_at;
        int nb;
        write_capacity(cap);
        send_idle_pct = idle;
        stall_pct     = stall;
        pause_at      = $urandom_range(count - 1);
        for (k = 0; k < count; k++)
        begin
            if (k == pause_at)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                case ($urandom_range(9))
                    0:       nb = 0;
                    7, 8:    nb = $urandom_range(32, 17);
                    9:       nb = $urandom_range(63, 33);
                    default: nb = $urandom_range(16, 1);
                endcase
                push_op(mfbp_pkg::FUNC_APPEND, $urandom, 6'(nb));
            end
            else if (pick < 91)
                push_op(mfbp_pkg::FUNC_FLUSH, $urandom, 6'($urandom_range(63)));
            else if (pick < 98)
                push_op(mfbp_pkg::FUNC_RESTART, $urandom, 6'($urandom_range(63)));
            else
                push_op(FUNC_UNUSED, $urandom, 6'($urandom_range(63)));
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default capacity: edge lengths, longest output burst, clamping
        push_op(mfbp_pkg::FUNC_FLUSH,   32'h0000_0000, 6'd0);   // nothing pending
        push_op(mfbp_pkg::FUNC_APPEND,  32'hFFFF_FFFF, 6'd0);   // empty append
        push_op(mfbp_pkg::FUNC_APPEND,  32'hFFFF_FFFF, 6'd32);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0000, 6'd32);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0005, 6'd3);
        push_op(mfbp_pkg::FUNC_FLUSH,   32'h0000_0000, 6'd0);   // zero padded byte
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_007F, 6'd7);
        push_op(mfbp_pkg::FUNC_APPEND,  32'hA5A5_A5A5, 6'd32);  // four bytes from one op
        push_op(mfbp_pkg::FUNC_APPEND,  32'h1234_5678, 6'd63);  // clamp to code width
        push_op(mfbp_pkg::FUNC_APPEND,  32'hDEAD_BEEF, 6'd40);
        push_op(FUNC_UNUSED,            32'hFFFF_FFFF, 6'd63);  // unused opcode
        push_op(mfbp_pkg::FUNC_RESTART, 32'h0000_0000, 6'd0);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0001, 6'd1);
        push_op(mfbp_pkg::FUNC_FLUSH,   32'h0000_0000, 6'd0);

        // Two-byte buffer: exact fit, then out of room
        write_capacity(13'd2);
        push_op(mfbp_pkg::FUNC_RESTART, 32'h0000_0000, 6'd0);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0ABC, 6'd12);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_000D, 6'd4);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0001, 6'd1);
        push_op(mfbp_pkg::FUNC_FLUSH,   32'h0000_0000, 6'd0);
        push_op(mfbp_pkg::FUNC_RESTART, 32'h0000_0000, 6'd0);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0005, 6'd3);

        // Drop capacity to zero under pending bits: negative room, lost flush
        write_capacity(13'd0);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0001, 6'd1);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0000, 6'd0);
        push_op(mfbp_pkg::FUNC_FLUSH,   32'h0000_0000, 6'd0);
        push_op(mfbp_pkg::FUNC_APPEND,  32'h0000_0000, 6'd0);

        run_random_phase(13'd8191, 0,  0,  60);
        run_random_phase(13'd1,    84, 0,  45);
        run_random_phase(13'd4096, 0,  84, 60);
        run_random_phase(13'd5,    33, 33, 55);
        run_random_phase(13'd37,   0,  0,  60);

        // Let any stray output show up before closing
        repeat (20) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected output transactions never arrived", expected_bytes.size());
            mismatches++;
        end

        $display("Ran %0d appends (%0d refused for room), %0d flushes, %0d restarts, %0d unused ops",
                 appends, rejects, flushes, restarts, unused_ops);
        $display("Compared %0d output transactions across seven capacities and four pacings",
                 bytes_checked);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
